/* hw/rtl/cpei_pkg.sv */
`timescale 1ns / 1ps

package cpei_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_NORMAL_W = 3'd3,
    REG_OFFSET   = 3'd4
  } cpei_reg_e;

  typedef logic [3:0][WORD_W-1:0] cpei_vec_t;

  typedef struct packed {
    cpei_vec_t         a;
    cpei_vec_t         b;
    logic [WORD_W-1:0] da;
    logic [WORD_W-1:0] db;
    logic              neg;
    logic              par;
  } cpei_side_t;

endpackage

/* hw/rtl/cpei_div.sv */
`timescale 1ns / 1ps

module cpei_div import cpei_pkg::*; #(
  parameter int NB = WORD_W + FRAC_BITS_DEF,
  parameter int DW = WORD_W,
  parameter int SW = $bits(cpei_side_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [NB-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q  [NB];
  logic [NB-1:0] num_q  [NB];
  logic [DW-1:0] rem_q  [NB];
  logic [DW-1:0] den_q  [NB];
  logic [SW-1:0] side_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic          vld_in;
    logic [NB-1:0] num_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [NB-1:0] num_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign num_in  = num_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial = {rem_in, num_in[NB-1]};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      num_d = {num_in[NB-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= num_d;
      rem_q[k]  <= rem_d;
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign vld_o  = vld_q[NB-1];
  assign quo_o  = num_q[NB-1];
  assign side_o = side_q[NB-1];

endmodule

/* hw/rtl/clip_plane_edge_intersect.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                                 Handshake
// request   in         a_x_i..a_w_i, b_x_i..b_w_i              start & !busy
// result    out        hit_*_o, dist_a_o, dist_b_o, edge_par.. done_o, one cycle
// config    in         cfg_idx_i, cfg_data_i                   cfg_we_i
//
// One request is accepted every cycle; busy is always low.
// The divider resolves one quotient bit per pipeline stage.
// Reset clears the plane registers and every valid bit of the pipeline.
// The receiver cannot stall, so the pipeline advances on every clock.

module clip_plane_edge_intersect import cpei_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] a_x_i,
  input  logic signed [WORD_W-1:0] a_y_i,
  input  logic signed [WORD_W-1:0] a_z_i,
  input  logic signed [WORD_W-1:0] a_w_i,
  input  logic signed [WORD_W-1:0] b_x_i,
  input  logic signed [WORD_W-1:0] b_y_i,
  input  logic signed [WORD_W-1:0] b_z_i,
  input  logic signed [WORD_W-1:0] b_w_i,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [WORD_W-1:0]        cfg_data_i,
  output logic                     done_o,
  output logic signed [WORD_W-1:0] hit_x_o,
  output logic signed [WORD_W-1:0] hit_y_o,
  output logic signed [WORD_W-1:0] hit_z_o,
  output logic signed [WORD_W-1:0] hit_w_o,
  output logic signed [WORD_W-1:0] dist_a_o,
  output logic signed [WORD_W-1:0] dist_b_o,
  output logic                     edge_parallel_o
);

  localparam int NB  = WORD_W + FRAC_BITS;
  localparam int PW  = 2 * WORD_W;
  localparam int AW  = PW + 3;
  localparam int MW  = 2 * WORD_W + 1;
  localparam int SW  = $bits(cpei_side_t);
  localparam int LAT = 6 + NB;
  localparam logic [WORD_W-1:0] S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] S_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  function automatic logic [WORD_W-1:0] sat_f(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'($signed({1'b0, S_MAX}));
    lo = AW'($signed(S_MIN));
    if (v > hi) return S_MAX;
    if (v < lo) return S_MIN;
    return v[WORD_W-1:0];
  endfunction

  logic [3:0][WORD_W-1:0] nrm_q;
  logic [WORD_W-1:0]      off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= '0;
      off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NORMAL_X: nrm_q[0] <= cfg_data_i;
        REG_NORMAL_Y: nrm_q[1] <= cfg_data_i;
        REG_NORMAL_Z: nrm_q[2] <= cfg_data_i;
        REG_NORMAL_W: nrm_q[3] <= cfg_data_i;
        REG_OFFSET:   off_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  cpei_vec_t in_a;
  cpei_vec_t in_b;
  assign in_a = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign in_b = {b_w_i, b_z_i, b_y_i, b_x_i};

  // Stage 1: products of the normal with both endpoints.
  logic               s1_vld_q;
  logic [3:0][PW-1:0] s1_pa_q;
  logic [3:0][PW-1:0] s1_pb_q;
  cpei_vec_t          s1_a_q;
  cpei_vec_t          s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= start & ~busy;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      s1_pa_q[i] <= PW'($signed(nrm_q[i]) * $signed(in_a[i]));
      s1_pb_q[i] <= PW'($signed(nrm_q[i]) * $signed(in_b[i]));
    end
    s1_a_q <= in_a;
    s1_b_q <= in_b;
  end

  // Stage 2: floored sums and saturated distances.
  logic signed [AW-1:0] acc_a;
  logic signed [AW-1:0] acc_b;
  logic                 s2_vld_q;
  logic [WORD_W-1:0]    s2_da_q;
  logic [WORD_W-1:0]    s2_db_q;
  cpei_vec_t            s2_a_q;
  cpei_vec_t            s2_b_q;

  always_comb begin
    acc_a = AW'($signed(off_q));
    acc_b = AW'($signed(off_q));
    for (int i = 0; i < 4; i++) begin
      acc_a = acc_a + AW'($signed(s1_pa_q[i]) >>> FRAC_BITS);
      acc_b = acc_b + AW'($signed(s1_pb_q[i]) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s2_da_q <= sat_f(acc_a);
    s2_db_q <= sat_f(acc_b);
    s2_a_q  <= s1_a_q;
    s2_b_q  <= s1_b_q;
  end

  // Stage 3: denominator and magnitudes for the divider.
  logic [WORD_W:0]   den;
  logic [WORD_W:0]   den_abs;
  logic [WORD_W:0]   da_abs;
  logic              s3_vld_q;
  logic [NB-1:0]     s3_num_q;
  logic [WORD_W-1:0] s3_den_q;
  cpei_side_t        s3_side_q;

  always_comb begin
    den     = {s2_da_q[WORD_W-1], s2_da_q} - {s2_db_q[WORD_W-1], s2_db_q};
    den_abs = den[WORD_W] ? (WORD_W+1)'(-den) : den;
    da_abs  = s2_da_q[WORD_W-1] ? (WORD_W+1)'(-{1'b1, s2_da_q}) : {1'b0, s2_da_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s3_num_q       <= {da_abs[WORD_W-1:0], {FRAC_BITS{1'b0}}};
    s3_den_q       <= den_abs[WORD_W-1:0];
    s3_side_q.a    <= s2_a_q;
    s3_side_q.b    <= s2_b_q;
    s3_side_q.da   <= s2_da_q;
    s3_side_q.db   <= s2_db_q;
    s3_side_q.neg  <= s2_da_q[WORD_W-1] ^ den[WORD_W];
    s3_side_q.par  <= (den == '0);
  end

  logic          dv_vld;
  logic [NB-1:0] dv_quo;
  cpei_side_t    dv_side;

  cpei_div #(
    .NB (NB),
    .DW (WORD_W),
    .SW (SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s3_vld_q),
    .num_i  (s3_num_q),
    .den_i  (s3_den_q),
    .side_i (s3_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // Signed, saturated parameter t.
  logic [WORD_W-1:0] t_d;
  logic              t_vld_q;
  logic [WORD_W-1:0] t_q;
  cpei_side_t        t_side_q;

  always_comb begin
    if (!dv_side.neg) begin
      t_d = (dv_quo > NB'(S_MAX)) ? S_MAX : dv_quo[WORD_W-1:0];
    end else begin
      t_d = (dv_quo > NB'(S_MIN)) ? S_MIN : WORD_W'(-dv_quo[WORD_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t_vld_q <= 1'b0;
    else         t_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    t_side_q <= dv_side;
  end

  // Products of the edge direction with t.
  logic               m_vld_q;
  logic [3:0][MW-1:0] m_prod_q;
  cpei_side_t         m_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else         m_vld_q <= t_vld_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      m_prod_q[i] <= MW'(($signed((WORD_W+1)'($signed(t_side_q.b[i])))
                        - $signed((WORD_W+1)'($signed(t_side_q.a[i]))))
                        * $signed(t_q));
    end
    m_side_q <= t_side_q;
  end

  // Output register.
  logic [3:0][WORD_W-1:0] hit_d;
  logic                   done_q;
  logic [3:0][WORD_W-1:0] hit_q;
  logic [WORD_W-1:0]      da_q;
  logic [WORD_W-1:0]      db_q;
  logic                   par_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (m_side_q.par) begin
        hit_d[i] = m_side_q.a[i];
      end else begin
        hit_d[i] = sat_f(AW'($signed(m_side_q.a[i]))
                         + AW'($signed(m_prod_q[i]) >>> FRAC_BITS));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= m_vld_q;
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    da_q  <= m_side_q.da;
    db_q  <= m_side_q.db;
    par_q <= m_side_q.par;
  end

  assign done_o          = done_q;
  assign hit_x_o         = hit_q[0];
  assign hit_y_o         = hit_q[1];
  assign hit_z_o         = hit_q[2];
  assign hit_w_o         = hit_q[3];
  assign dist_a_o        = da_q;
  assign dist_b_o        = db_q;
  assign edge_parallel_o = par_q;

  a_par_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (edge_parallel_o == (dist_a_o == dist_b_o)))
    else $error("parallel flag disagrees with the distances");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("request did not produce a result after the pipeline latency");

  a_t_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_vld_q && !t_side_q.par && (t_side_q.da == '0)) |-> (t_q == '0))
    else $error("zero distance gave a nonzero parameter");

endmodule
